### rtl/vec3_arith_unit_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the vector arithmetic unit RTL.
// ---------------------------------------------------------------------------
`ifndef VEC3_ARITH_UNIT_CORE_DEFINES_SVH
`define VEC3_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define V3A_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define V3A_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/v3a_pkg.sv
// ---------------------------------------------------------------------------
// v3a_pkg
// Operation codes shared by the vector arithmetic unit modules.
// ---------------------------------------------------------------------------
package v3a_pkg;

  localparam int OP_W = 4;

  // Operation code carried by each item.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_SCALE  = 4'd2,
    OP_DIV    = 4'd3,
    OP_NEG    = 4'd4,
    OP_DOT    = 4'd5,
    OP_CROSS  = 4'd6,
    OP_LENGTH = 4'd7,
    OP_NORM   = 4'd8
  } op_e;

endpackage

### rtl/v3a_mul.sv
// ---------------------------------------------------------------------------
// v3a_mul
// Two-stage signed multiplier built from four half-width partial products.
// ---------------------------------------------------------------------------
module v3a_mul #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int H  = W / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;

  logic signed [HW-1:0]   a_hi, b_hi;
  logic        [H-1:0]    a_lo, b_lo;
  logic signed [2*HW-1:0] hh_d, hh_q;
  logic signed [W:0]      hl_d, hl_q, lh_d, lh_q;
  logic        [2*H-1:0]  ll_d, ll_q;
  logic signed [PW-1:0]   e_hh, e_hl, e_lh, e_ll, p_d, p_q;

  // Split the operands into a signed upper half and an unsigned lower half.
  assign a_hi = a_i[W-1:H];
  assign b_hi = b_i[W-1:H];
  assign a_lo = a_i[H-1:0];
  assign b_lo = b_i[H-1:0];

  // First stage: the four partial products.
  assign hh_d = a_hi * b_hi;
  assign hl_d = a_hi * $signed({1'b0, b_lo});
  assign lh_d = $signed({1'b0, a_lo}) * b_hi;
  assign ll_d = a_lo * b_lo;

  always_ff @(posedge clk_i) begin
    hh_q <= hh_d;
    hl_q <= hl_d;
    lh_q <= lh_d;
    ll_q <= ll_d;
  end

  // Second stage: align and sum the partial products.
  assign e_hh = hh_q;
  assign e_hl = hl_q;
  assign e_lh = lh_q;
  assign e_ll = $signed({{(PW-2*H){1'b0}}, ll_q});
  assign p_d  = (e_hh <<< (2*H)) + (e_hl <<< H) + (e_lh <<< H) + e_ll;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### rtl/v3a_lane.sv
// ---------------------------------------------------------------------------
// v3a_lane
// One component lane: picks the operand pairs for the current operation and
// forms the two products this lane contributes.
// ---------------------------------------------------------------------------
module v3a_lane
  import v3a_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  op_e                   op_i,
  input  logic signed [W-1:0]   a_self_i,
  input  logic signed [W-1:0]   a_next_i,
  input  logic signed [W-1:0]   a_prev_i,
  input  logic signed [W-1:0]   b_self_i,
  input  logic signed [W-1:0]   b_next_i,
  input  logic signed [W-1:0]   b_prev_i,
  input  logic signed [W-1:0]   scalar_i,
  output logic signed [2*W-1:0] prod1_o,
  output logic signed [2*W-1:0] prod2_o
);

  logic signed [W-1:0] m1_a, m1_b, m2_a, m2_b;

  // Operand selection for the main multiplier.
  always_comb begin
    m1_a = a_self_i;
    m1_b = b_self_i;
    case (op_i)
      OP_SCALE: begin
        m1_b = scalar_i;
      end
      OP_CROSS: begin
        m1_a = a_next_i;
        m1_b = b_prev_i;
      end
      OP_LENGTH, OP_NORM: begin
        m1_b = a_self_i;
      end
      default: begin
      end
    endcase
  end

  // The second multiplier only serves the cross product.
  assign m2_a = a_prev_i;
  assign m2_b = b_next_i;

  v3a_mul #(.W(W)) u_mul1 (
    .clk_i (clk_i),
    .a_i   (m1_a),
    .b_i   (m1_b),
    .p_o   (prod1_o)
  );

  v3a_mul #(.W(W)) u_mul2 (
    .clk_i (clk_i),
    .a_i   (m2_a),
    .b_i   (m2_b),
    .p_o   (prod2_o)
  );

endmodule

### rtl/v3a_sqrt.sv
// ---------------------------------------------------------------------------
// v3a_sqrt
// Pipelined integer square root, one root bit per stage, with a side payload
// that travels alongside.
// ---------------------------------------------------------------------------
module v3a_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*W-1:0]  rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [W-1:0]    root_o,
  output logic [SW-1:0]   side_o
);

  localparam int PW = 2 * W;
  localparam int RW = W + 4;

  logic          lv_v    [W+1];
  logic [PW-1:0] lv_rad  [W+1];
  logic [W-1:0]  lv_root [W+1];
  logic [RW-1:0] lv_rem  [W+1];
  logic [SW-1:0] lv_side [W+1];

  assign lv_v[0]    = valid_i;
  assign lv_rad[0]  = rad_i;
  assign lv_root[0] = '0;
  assign lv_rem[0]  = '0;
  assign lv_side[0] = side_i;

  // Each stage brings in two radicand bits and decides one root bit.
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0] rem_sh, trial, rem_d, rem_q;
    logic          ge, v_q;
    logic [PW-1:0] rad_q;
    logic [W-1:0]  root_q;
    logic [SW-1:0] side_q;

    assign rem_sh = {lv_rem[k][RW-3:0], lv_rad[k][PW-1 -: 2]};
    assign trial  = RW'({lv_root[k], 2'b01});
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= lv_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      rad_q  <= lv_rad[k] << 2;
      root_q <= {lv_root[k][W-2:0], ge};
      side_q <= lv_side[k];
    end

    assign lv_v[k+1]    = v_q;
    assign lv_rad[k+1]  = rad_q;
    assign lv_root[k+1] = root_q;
    assign lv_rem[k+1]  = rem_q;
    assign lv_side[k+1] = side_q;
  end

  assign valid_o = lv_v[W];
  assign root_o  = lv_root[W];
  assign side_o  = lv_side[W];

endmodule

### rtl/v3a_div.sv
// ---------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider for one lane, one quotient bit per stage,
// with a side payload that travels alongside.
// ---------------------------------------------------------------------------
module v3a_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [W+F-1:0]  num_i,
  input  logic [W-1:0]    den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [W+F-1:0]  quot_o,
  output logic [SW-1:0]   side_o
);

  localparam int Q = W + F;

  logic          lv_v    [Q+1];
  logic [Q-1:0]  lv_num  [Q+1];
  logic [Q-1:0]  lv_quot [Q+1];
  logic [W-1:0]  lv_rem  [Q+1];
  logic [W-1:0]  lv_den  [Q+1];
  logic [SW-1:0] lv_side [Q+1];

  assign lv_v[0]    = valid_i;
  assign lv_num[0]  = num_i;
  assign lv_quot[0] = '0;
  assign lv_rem[0]  = '0;
  assign lv_den[0]  = den_i;
  assign lv_side[0] = side_i;

  // Each stage shifts in one dividend bit and tries one subtraction.
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [W:0]    rem_sh, diff;
    logic          ge, v_q;
    logic [W-1:0]  rem_q, den_q;
    logic [Q-1:0]  num_q, quot_q;
    logic [SW-1:0] side_q;

    assign rem_sh = {lv_rem[k], lv_num[k][Q-1]};
    assign diff   = rem_sh - {1'b0, lv_den[k]};
    assign ge     = (rem_sh >= {1'b0, lv_den[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= lv_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      num_q  <= lv_num[k] << 1;
      quot_q <= {lv_quot[k][Q-2:0], ge};
      den_q  <= lv_den[k];
      side_q <= lv_side[k];
    end

    assign lv_v[k+1]    = v_q;
    assign lv_num[k+1]  = num_q;
    assign lv_quot[k+1] = quot_q;
    assign lv_rem[k+1]  = rem_q;
    assign lv_den[k+1]  = den_q;
    assign lv_side[k+1] = side_q;
  end

  assign valid_o = lv_v[Q];
  assign quot_o  = lv_quot[Q];
  assign side_o  = lv_side[Q];

endmodule

### rtl/vec3_arith_unit_core.sv
// ---------------------------------------------------------------------------
// vec3_arith_unit_core
// Signed fixed-point three-component vector unit: add, subtract, scale,
// divide, negate, dot, cross, length and normalize.
// ---------------------------------------------------------------------------
// Usage:
//   An item (op_i, vectors a and b, scalar_i) is taken at each rising edge
//   where start is high and busy is low. busy stays low: the unit is fully
//   pipelined and takes one item every cycle, with no gaps.
//   Each item gives one result on rx_o, ry_o, rz_o, rs_o and overflow_o,
//   marked by valid_o for exactly one cycle. Results leave in item order.
//   Between acceptance and result, an item passes the two multiply stages,
//   two sum and rounding stages, the square-root pipeline (one stage per
//   root bit) and the divider pipeline (one stage per quotient bit), then
//   the output register.
//   Every item passes every stage, so simple operations take as long as
//   normalize and results never reorder.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; a result not taken in its cycle is gone.
// ---------------------------------------------------------------------------
`include "vec3_arith_unit_core_defines.svh"

module vec3_arith_unit_core
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             op_i,
  input  logic signed [WORD_BITS-1:0] ax_i,
  input  logic signed [WORD_BITS-1:0] ay_i,
  input  logic signed [WORD_BITS-1:0] az_i,
  input  logic signed [WORD_BITS-1:0] bx_i,
  input  logic signed [WORD_BITS-1:0] by_i,
  input  logic signed [WORD_BITS-1:0] bz_i,
  input  logic signed [WORD_BITS-1:0] scalar_i,
  output logic                        valid_o,
  output logic signed [WORD_BITS-1:0] rx_o,
  output logic signed [WORD_BITS-1:0] ry_o,
  output logic signed [WORD_BITS-1:0] rz_o,
  output logic signed [WORD_BITS-1:0] rs_o,
  output logic                        overflow_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int Q  = W + F;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 2;

  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Side payload through the square root, and the extra fields of lane 0.
  typedef struct packed {
    op_e                 op;
    logic [2:0][W-1:0]   a;
    logic [W-1:0]        sc;
    logic [2:0][W-1:0]   r;
    logic [W-1:0]        rs;
    logic                ov;
  } sq_side_t;

  typedef struct packed {
    sq_side_t     base;
    logic [W-1:0] len;
    logic         sgn;
  } dv_side_t;

  // Saturate a sum one bit wider than a word; returns {overflow, value}.
  function automatic logic [W:0] sat_wp1(input logic [W:0] x);
    if (x[W] != x[W-1]) begin
      return {1'b1, x[W], {(W-1){~x[W]}}};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  // Drop the fraction bits toward zero and saturate; returns {overflow, value}.
  function automatic logic [W:0] fix_sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] t;
    logic [XW-W:0]        hi;
    t = x >>> F;
    if (x[XW-1] && (x[F-1:0] != '0)) begin
      t = t + XW'(1);
    end
    hi = t[XW-1:W-1];
    if ((hi != '0) && (hi != '1)) begin
      return {1'b1, t[XW-1], {(W-1){~t[XW-1]}}};
    end
    return {1'b0, t[W-1:0]};
  endfunction

  // Apply the sign to a quotient magnitude and saturate.
  function automatic logic [W:0] quot_sat(input logic [Q-1:0] q, input logic sgn);
    if (sgn && (q != '0)) begin
      if (q > Q'(MIN_V)) begin
        return {1'b1, MIN_V};
      end
      return {1'b0, W'(-q[W-1:0])};
    end
    if (q > Q'(MAX_V)) begin
      return {1'b1, MAX_V};
    end
    return {1'b0, q[W-1:0]};
  endfunction

  logic signed [W-1:0] a_in [3];
  logic signed [W-1:0] b_in [3];
  op_e                 op_in;

  assign a_in[0] = ax_i;
  assign a_in[1] = ay_i;
  assign a_in[2] = az_i;
  assign b_in[0] = bx_i;
  assign b_in[1] = by_i;
  assign b_in[2] = bz_i;
  assign op_in   = op_e'(op_i);

  // The pipeline never holds items off.
  assign busy = 1'b0;

  // ------------------------------------------------------------------
  // Stage 1: register the item and the add, subtract and negate results.
  // ------------------------------------------------------------------
  logic         v1_q, v2_q, v3_q, v4_q;
  op_e          op1_q, op2_q, op3_q, op4_q;
  logic [W-1:0] a1_q [3], a2_q [3], a3_q [3], a4_q [3];
  logic [W-1:0] s1_q, s2_q, s3_q, s4_q;
  logic [W-1:0] r1_d [3], r1_q [3], r2_q [3], r3_q [3];
  logic         ov1_d, ov1_q, ov2_q, ov3_q;

  always_comb begin
    logic [W:0] t;
    ov1_d = 1'b0;
    t     = '0;
    for (int i = 0; i < 3; i++) begin
      r1_d[i] = '0;
    end
    case (op_in)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          t = sat_wp1({a_in[i][W-1], a_in[i]} + {b_in[i][W-1], b_in[i]});
          r1_d[i] = t[W-1:0];
          ov1_d   = ov1_d | t[W];
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          t = sat_wp1({a_in[i][W-1], a_in[i]} - {b_in[i][W-1], b_in[i]});
          r1_d[i] = t[W-1:0];
          ov1_d   = ov1_d | t[W];
        end
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          t = sat_wp1({(W+1){1'b0}} - {a_in[i][W-1], a_in[i]});
          r1_d[i] = t[W-1:0];
          ov1_d   = ov1_d | t[W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 2 only delays the item while the lane multipliers finish.
  always_ff @(posedge clk_i) begin
    op1_q <= op_in;
    s1_q  <= scalar_i;
    ov1_q <= ov1_d;
    op2_q <= op1_q;
    s2_q  <= s1_q;
    ov2_q <= ov1_q;
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= a_in[i];
      r1_q[i] <= r1_d[i];
      a2_q[i] <= a1_q[i];
      r2_q[i] <= r1_q[i];
    end
  end

  // ------------------------------------------------------------------
  // Lanes: one per component, each with its own multipliers.
  // ------------------------------------------------------------------
  logic signed [PW-1:0] prod1 [3];
  logic signed [PW-1:0] prod2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane #(.W(W)) u_lane (
      .clk_i    (clk_i),
      .op_i     (op_in),
      .a_self_i (a_in[i]),
      .a_next_i (a_in[(i+1)%3]),
      .a_prev_i (a_in[(i+2)%3]),
      .b_self_i (b_in[i]),
      .b_next_i (b_in[(i+1)%3]),
      .b_prev_i (b_in[(i+2)%3]),
      .scalar_i (scalar_i),
      .prod1_o  (prod1[i]),
      .prod2_o  (prod2[i])
    );
  end

  // ------------------------------------------------------------------
  // Stage 3: merge the lane products into exact sums and differences.
  // ------------------------------------------------------------------
  logic signed [XW-1:0] x3_d [3], x3_q [3];
  logic signed [XW-1:0] dot3_d, dot3_q;
  logic [PW-1:0]        sq3_d, sq3_q;

  always_comb begin
    logic signed [XW-1:0] p1x [3];
    logic signed [XW-1:0] p2x [3];
    for (int i = 0; i < 3; i++) begin
      p1x[i]  = XW'(prod1[i]);
      p2x[i]  = XW'(prod2[i]);
      x3_d[i] = (op2_q == OP_CROSS) ? (p1x[i] - p2x[i]) : p1x[i];
    end
    dot3_d = p1x[0] + p1x[1] + p1x[2];
    sq3_d  = $unsigned(prod1[0]) + $unsigned(prod1[1]) + $unsigned(prod1[2]);
  end

  always_ff @(posedge clk_i) begin
    op3_q  <= op2_q;
    s3_q   <= s2_q;
    ov3_q  <= ov2_q;
    dot3_q <= dot3_d;
    sq3_q  <= sq3_d;
    for (int i = 0; i < 3; i++) begin
      a3_q[i] <= a2_q[i];
      r3_q[i] <= r2_q[i];
      x3_q[i] <= x3_d[i];
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: round toward zero and saturate the product results.
  // ------------------------------------------------------------------
  logic [W-1:0]  r4_d [3], r4_q [3];
  logic [W-1:0]  rs4_d, rs4_q;
  logic          ov4_d, ov4_q;
  logic [PW-1:0] rad4_q;

  always_comb begin
    logic [W:0] t;
    t     = '0;
    rs4_d = '0;
    ov4_d = ov3_q;
    for (int i = 0; i < 3; i++) begin
      r4_d[i] = '0;
    end
    case (op3_q)
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          r4_d[i] = r3_q[i];
        end
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t       = fix_sat(x3_q[i]);
          r4_d[i] = t[W-1:0];
          ov4_d   = ov4_d | t[W];
        end
      end
      OP_DOT: begin
        t     = fix_sat(dot3_q);
        rs4_d = t[W-1:0];
        ov4_d = ov4_d | t[W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    op4_q  <= op3_q;
    s4_q   <= s3_q;
    rs4_q  <= rs4_d;
    ov4_q  <= ov4_d;
    rad4_q <= sq3_q;
    for (int i = 0; i < 3; i++) begin
      a4_q[i] <= a3_q[i];
      r4_q[i] <= r4_d[i];
    end
  end

  // ------------------------------------------------------------------
  // Square root of the squared length.
  // ------------------------------------------------------------------
  sq_side_t     sq_in, sq_out;
  logic         sq_valid;
  logic [W-1:0] len;

  always_comb begin
    sq_in.op = op4_q;
    sq_in.sc = s4_q;
    sq_in.rs = rs4_q;
    sq_in.ov = ov4_q;
    for (int i = 0; i < 3; i++) begin
      sq_in.a[i] = a4_q[i];
      sq_in.r[i] = r4_q[i];
    end
  end

  v3a_sqrt #(.W(W), .SW($bits(sq_side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rad_i   (rad4_q),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (len),
    .side_o  (sq_out)
  );

  // ------------------------------------------------------------------
  // Per-lane dividers: by the scalar for divide, by the length for normalize.
  // ------------------------------------------------------------------
  logic [W-1:0] den;
  logic [W-1:0] s_mag;
  logic [Q-1:0] num [3];
  logic         sgn [3];
  dv_side_t     dv_in, dv_out;
  logic         dv_valid, dv_valid1, dv_valid2;
  logic [Q-1:0] quot [3];
  logic         sgn1_out, sgn2_out;

  always_comb begin
    logic [W-1:0] a_mag;
    logic         s_neg;
    a_mag = '0;
    s_neg = (sq_out.op == OP_DIV) && sq_out.sc[W-1];
    s_mag = sq_out.sc[W-1] ? (W'(0) - sq_out.sc) : sq_out.sc;
    den   = (sq_out.op == OP_DIV) ? s_mag : len;
    for (int i = 0; i < 3; i++) begin
      a_mag  = sq_out.a[i][W-1] ? (W'(0) - sq_out.a[i]) : sq_out.a[i];
      num[i] = {a_mag, {F{1'b0}}};
      sgn[i] = sq_out.a[i][W-1] ^ s_neg;
    end
    dv_in.base = sq_out;
    dv_in.len  = len;
    dv_in.sgn  = sgn[0];
  end

  v3a_div #(.W(W), .F(F), .SW($bits(dv_side_t))) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .num_i   (num[0]),
    .den_i   (den),
    .side_i  (dv_in),
    .valid_o (dv_valid),
    .quot_o  (quot[0]),
    .side_o  (dv_out)
  );

  v3a_div #(.W(W), .F(F), .SW(1)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .num_i   (num[1]),
    .den_i   (den),
    .side_i  (sgn[1]),
    .valid_o (dv_valid1),
    .quot_o  (quot[1]),
    .side_o  (sgn2_out)
  );

  v3a_div #(.W(W), .F(F), .SW(1)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .num_i   (num[2]),
    .den_i   (den),
    .side_i  (sgn[2]),
    .valid_o (dv_valid2),
    .quot_o  (quot[2]),
    .side_o  (sgn1_out)
  );

  // ------------------------------------------------------------------
  // Final selection and the output register.
  // ------------------------------------------------------------------
  logic [W-1:0] fr_d [3];
  logic [W-1:0] frs_d;
  logic         fov_d;
  logic         fin_dz;
  logic         out_v_q;
  logic [W-1:0] rx_q, ry_q, rz_q, rs_q;
  logic         ov_q;
  op_e          op_out_q;

  assign fin_dz = dv_valid && (dv_out.base.op == OP_DIV) && (dv_out.base.sc == '0);

  always_comb begin
    logic [W:0] t;
    logic       qs [3];
    t     = '0;
    qs[0] = dv_out.sgn;
    qs[1] = sgn2_out;
    qs[2] = sgn1_out;
    frs_d = '0;
    fov_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fr_d[i] = '0;
    end
    case (dv_out.base.op)
      OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          fr_d[i] = dv_out.base.r[i];
        end
        fov_d = dv_out.base.ov;
      end
      OP_DOT: begin
        frs_d = dv_out.base.rs;
        fov_d = dv_out.base.ov;
      end
      OP_LENGTH: begin
        if (dv_out.len[W-1]) begin
          frs_d = MAX_V;
          fov_d = 1'b1;
        end else begin
          frs_d = dv_out.len;
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (dv_out.len == '0) begin
            fr_d[i] = dv_out.base.a[i];
          end else begin
            t       = quot_sat(quot[i], qs[i]);
            fr_d[i] = t[W-1:0];
            fov_d   = fov_d | t[W];
          end
        end
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (dv_out.base.sc == '0) begin
            // Divide by zero: saturate by sign, zero stays zero.
            fov_d = 1'b1;
            if (dv_out.base.a[i][W-1]) begin
              fr_d[i] = MIN_V;
            end else if (dv_out.base.a[i] != '0) begin
              fr_d[i] = MAX_V;
            end
          end else begin
            t       = quot_sat(quot[i], qs[i]);
            fr_d[i] = t[W-1:0];
            fov_d   = fov_d | t[W];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_valid & dv_valid1 & dv_valid2;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q     <= fr_d[0];
    ry_q     <= fr_d[1];
    rz_q     <= fr_d[2];
    rs_q     <= frs_d;
    ov_q     <= fov_d;
    op_out_q <= dv_out.base.op;
  end

  assign valid_o    = out_v_q;
  assign rx_o       = rx_q;
  assign ry_o       = ry_q;
  assign rz_o       = rz_q;
  assign rs_o       = rs_q;
  assign overflow_o = ov_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `V3A_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, start, v1_q, "accepted item did not enter")

  `V3A_ASSERT_IMP(a_len_nonneg, clk_i, rst_ni, (valid_o && (op_out_q == OP_LENGTH)), (!rs_q[W-1]), "length result is negative")

  `V3A_ASSERT_IMP(a_dz_flag, clk_i, rst_ni, (valid_o && $past(fin_dz)), ov_q, "divide by zero without overflow")

  `V3A_ASSERT_IMP(a_scalar_vec_zero, clk_i, rst_ni, (valid_o && ((op_out_q == OP_DOT) || (op_out_q == OP_LENGTH))), ((rx_q == '0) && (ry_q == '0) && (rz_q == '0)), "vector output not zero for scalar op")

endmodule

### tb/tb_vec3_arith_unit_core.sv
// ---------------------------------------------------------------------------
// tb_vec3_arith_unit_core
// Self-checking bench for the fixed-point vector unit. A queue of directed
// and random items feeds a clocked driver; a clocked monitor predicts each
// accepted item in wide integer arithmetic and checks every result in order.
// ---------------------------------------------------------------------------
module tb_vec3_arith_unit_core;
  import v3a_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int LATENCY   = 2 * WORD_BITS + FRAC_BITS + 4;
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM  = 1000;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct {
    logic [OP_W-1:0] op;
    word_t ax, ay, az, bx, by, bz, sc;
    bit drain;  // hold this item back until every result has come
  } vec_item_t;

  typedef struct {
    word_t rx, ry, rz, rs;
    logic ov;
  } vec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] op_i = '0;
  word_t ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  word_t scalar_i = '0;
  logic valid_o, overflow_o;
  word_t rx_o, ry_o, rz_o, rs_o;

  vec_item_t   pending_items[$];
  vec_result_t expected_results[$];
  int  n_errors = 0;
  int  n_sent = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  bit  took_item = 1'b0;

  vec3_arith_unit_core #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .ax_i, .ay_i, .az_i, .bx_i, .by_i,
    .bz_i, .scalar_i, .valid_o, .rx_o, .ry_o, .rz_o, .rs_o, .overflow_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Clamp a wide value into the word range, noting saturation.
  function automatic word_t clamp_word(wide_t v, inout logic ov);
    if (v > wide_t'(WMAX)) begin
      ov = 1'b1;
      return WMAX;
    end
    if (v < wide_t'(WMIN)) begin
      ov = 1'b1;
      return WMIN;
    end
    return word_t'(v);
  endfunction

  // Drop the fraction bits of an exact value, rounding toward zero.
  function automatic wide_t drop_frac(wide_t v);
    if (v < 0) return -((-v) >>> FRAC_BITS);
    return v >>> FRAC_BITS;
  endfunction

  // Integer square root, rounded down.
  function automatic wide_t floor_root(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return wide_t'(r);
  endfunction

  // Expected result of one item.
  function automatic vec_result_t vector_op_result(vec_item_t it);
    vec_result_t res;
    wide_t a[3], b[3], s, rv[3], len, sum;
    logic ov;
    ov = 1'b0;
    a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
    b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
    s = it.sc;
    rv[0] = 0; rv[1] = 0; rv[2] = 0;
    res.rs = '0;
    case (it.op)
      OP_ADD:   for (int i = 0; i < 3; i++) rv[i] = clamp_word(a[i] + b[i], ov);
      OP_SUB:   for (int i = 0; i < 3; i++) rv[i] = clamp_word(a[i] - b[i], ov);
      OP_SCALE: for (int i = 0; i < 3; i++) rv[i] = clamp_word(drop_frac(a[i] * s), ov);
      OP_DIV: begin
        if (s == 0) begin
          ov = 1'b1;
          for (int i = 0; i < 3; i++)
            rv[i] = a[i] > 0 ? wide_t'(WMAX) : (a[i] < 0 ? wide_t'(WMIN) : 0);
        end else begin
          for (int i = 0; i < 3; i++)
            rv[i] = clamp_word((a[i] <<< FRAC_BITS) / s, ov);
        end
      end
      OP_NEG:   for (int i = 0; i < 3; i++) rv[i] = clamp_word(-a[i], ov);
      OP_DOT: begin
        sum = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.rs = clamp_word(drop_frac(sum), ov);
      end
      OP_CROSS: begin
        rv[0] = clamp_word(drop_frac(a[1] * b[2] - a[2] * b[1]), ov);
        rv[1] = clamp_word(drop_frac(a[2] * b[0] - a[0] * b[2]), ov);
        rv[2] = clamp_word(drop_frac(a[0] * b[1] - a[1] * b[0]), ov);
      end
      OP_LENGTH, OP_NORM: begin
        len = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (it.op == OP_LENGTH) begin
          res.rs = clamp_word(len, ov);
        end else if (len == 0) begin
          for (int i = 0; i < 3; i++) rv[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++)
            rv[i] = clamp_word((a[i] <<< FRAC_BITS) / len, ov);
        end
      end
      default: ;
    endcase
    res.rx = word_t'(rv[0]);
    res.ry = word_t'(rv[1]);
    res.rz = word_t'(rv[2]);
    res.ov = ov;
    return res;
  endfunction

  // Random component: full range, small magnitudes or edge values.
  function automatic word_t rand_component();
    word_t edges[6];
    int mode;
    edges[0] = WMIN; edges[1] = WMAX; edges[2] = '0;
    edges[3] = -1; edges[4] = 1; edges[5] = word_t'(1 << FRAC_BITS);
    mode = $urandom_range(0, 9);
    if (mode < 4) return word_t'($urandom);
    if (mode < 9) return word_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    return edges[$urandom_range(0, 5)];
  endfunction

  function automatic vec_item_t make_item(logic [OP_W-1:0] op, word_t ax, word_t ay,
                                          word_t az, word_t bx, word_t by, word_t bz,
                                          word_t sc);
    vec_item_t it;
    it.op = op; it.ax = ax; it.ay = ay; it.az = az;
    it.bx = bx; it.by = by; it.bz = bz; it.sc = sc; it.drain = 1'b0;
    return it;
  endfunction

  // Stimulus: directed corners first, then random items.
  initial begin
    vec_item_t it;
    word_t one;
    one = word_t'(1 << FRAC_BITS);
    pending_items.push_back(make_item(OP_ADD, WMAX, WMIN, 5, 1, -1, 7, 0));
    pending_items.push_back(make_item(OP_ADD, WMIN, WMAX, -3, -1, 1, 4, 0));
    pending_items.push_back(make_item(OP_SUB, WMIN, WMAX, 0, 1, -1, WMIN, 0));
    pending_items.push_back(make_item(OP_SCALE, WMAX, WMIN, one, 0, 0, 0, WMAX));
    pending_items.push_back(make_item(OP_SCALE, -3, 3, one, 0, 0, 0, 1));
    pending_items.push_back(make_item(OP_SCALE, WMIN, one, -one, 0, 0, 0, WMIN));
    // Division by zero: signed components saturate, a zero one stays zero.
    pending_items.push_back(make_item(OP_DIV, 5, -5, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_DIV, WMAX, WMIN, one, 0, 0, 0, 1));
    pending_items.push_back(make_item(OP_DIV, WMIN, -one, 7, 0, 0, 0, -1));
    pending_items.push_back(make_item(OP_DIV, one, -one, 3, 0, 0, 0, WMIN));
    pending_items.push_back(make_item(OP_NEG, WMIN, WMAX, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    pending_items.push_back(make_item(OP_DOT, WMIN, 1, -1, WMAX, -1, 1, 0));
    pending_items.push_back(make_item(OP_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0));
    pending_items.push_back(make_item(OP_CROSS, one, 0, 0, 0, one, 0, 0));
    pending_items.push_back(make_item(OP_LENGTH, WMIN, WMIN, WMIN, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_LENGTH, 3 * one, 4 * one, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_LENGTH, 0, 0, 0, 0, 0, 0, 0));
    // Normalizing a zero vector passes it through.
    pending_items.push_back(make_item(OP_NORM, 0, 0, 0, 1, 2, 3, 4));
    pending_items.push_back(make_item(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, WMIN, WMIN, WMAX, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, -3 * one, 4 * one, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(4'd9, WMAX, WMAX, WMAX, 1, 1, 1, 1));
    pending_items.push_back(make_item(4'd15, WMIN, -1, 1, -1, 1, WMIN, -1));
    for (int n = 0; n < N_RANDOM; n++) begin
      it = make_item(OP_W'($urandom_range(0, 99) < 4 ? $urandom_range(9, 15)
                                                     : $urandom_range(0, 8)),
                     rand_component(), rand_component(), rand_component(),
                     rand_component(), rand_component(), rand_component(),
                     $urandom_range(0, 19) == 0 ? word_t'(0) : rand_component());
      // Let the pipeline empty completely twice.
      it.drain = (n == 200) || (n == 700);
      pending_items.push_back(it);
    end
  end

  // Driver: presents a new item once the previous one was taken, or idles.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took_item)) begin
      if (pending_items.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_items[0].drain && expected_results.size() != 0) begin
        start <= 1'b0;
      end else if (!(n_sent >= 300 && n_sent < 500) && $urandom_range(0, 99) < 9) begin
        start <= 1'b0;
      end else begin
        vec_item_t it;
        it = pending_items.pop_front();
        start <= 1'b1;
        op_i <= it.op;
        ax_i <= it.ax; ay_i <= it.ay; az_i <= it.az;
        bx_i <= it.bx; by_i <= it.by; bz_i <= it.bz;
        scalar_i <= it.sc;
        n_sent <= n_sent + 1;
      end
    end
  end

  // Monitor: checks each result, then records the item taken at this edge.
  always @(posedge clk_i) begin
    vec_result_t want;
    vec_item_t it;
    took_item <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (rx_o !== want.rx) begin
            $error("rx: expected %0d, got %0d", want.rx, rx_o); n_errors++;
          end
          if (ry_o !== want.ry) begin
            $error("ry: expected %0d, got %0d", want.ry, ry_o); n_errors++;
          end
          if (rz_o !== want.rz) begin
            $error("rz: expected %0d, got %0d", want.rz, rz_o); n_errors++;
          end
          if (rs_o !== want.rs) begin
            $error("rs: expected %0d, got %0d", want.rs, rs_o); n_errors++;
          end
          if (overflow_o !== want.ov) begin
            $error("overflow: expected %0b, got %0b", want.ov, overflow_o); n_errors++;
          end
        end
      end
      if (start && !busy) begin
        it = make_item(op_i, ax_i, ay_i, az_i, bx_i, by_i, bz_i, scalar_i);
        expected_results.push_back(vector_op_result(it));
      end
      // Watchdog on cycles where nothing moves.
      if ((start && !busy) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Reset, then wait for all items and results before judging the run.
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done && expected_results.size() == 0);
    repeat (LATENCY + 16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/v3a_pkg.sv
rtl/v3a_mul.sv
rtl/v3a_lane.sv
rtl/v3a_sqrt.sv
rtl/v3a_div.sv
rtl/vec3_arith_unit_core.sv
tb/tb_vec3_arith_unit_core.sv
